### src/bssc_pkg.sv
// Shared types and constants for the BDF2 step-size controller.
// Used by the multiply-divide unit, the top-level sequencer and the testbench.
package bssc_pkg;

  localparam int MAX_ITER  = 16;
  localparam int FRAC_BITS = 24;
  localparam int ITER_W    = $clog2(MAX_ITER + 1);

  localparam logic [63:0] ONE_Q32 = 64'h0000_0001_0000_0000;
  localparam logic [63:0] R_CAP   = 64'h0000_0200_0000_0000;
  localparam logic [63:0] PQ_CAP  = 64'h0010_0000_0000_0000;
  localparam logic [63:0] T_CAP   = 64'h0100_0000_0000_0000;
  localparam logic [9:0]  TOL_INV = 10'd1000;

  // Register indexes of the configuration port.
  localparam logic [1:0] REG_RATIO_MIN    = 2'd0;
  localparam logic [1:0] REG_RATIO_MAX    = 2'd1;
  localparam logic [1:0] REG_REJECT_LIMIT = 2'd2;
  localparam logic [1:0] REG_ERROR_FLOOR  = 2'd3;

  // Request to the shared multiply-divide unit: floor(a*b/d), saturated.
  typedef struct packed {
    logic        start;
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] d;
  } md_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] q;
  } md_rsp_t;

endpackage

### src/bdf2_step_size_controller.sv
// BDF2 step-size controller: sequencer around one shared multiply-divide unit.
// Error control off, a rejected step or h of 0 skip the solve; the done state registers the result.
// A solve runs 2 setup, 5 per Newton iteration (up to 16) and 3 clamp operations,
// each a restoring divide, a shift for divisor 2^32 or 2^FRAC_BITS, or a saturation.
// One request at a time; the next is taken the cycle after the result is registered.
// Synchronous active-high reset clears control state and loads register defaults.
module bdf2_step_size_controller (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] step_now,
  input  logic [31:0] hist_delta_one,
  input  logic [31:0] hist_delta_two,
  input  logic [31:0] pred_error,
  input  logic        freeze_active,
  input  logic        error_control_on,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] next_step,
  output logic        step_status,
  output logic        newton_converged
);

  typedef enum logic [3:0] {
    S_IDLE, S_P, S_Q, S_A, S_T1, S_T2, S_DEN, S_DX, S_N, S_LO, S_HI, S_DONE
  } state_t;

  state_t                    state;
  logic [31:0]               ratio_min, ratio_max, reject_limit, error_floor;
  logic [31:0]               h, d2;
  logic                      frozen;
  logic [63:0]               e, p, q, r, a, t, rp, nxt, lo;
  logic [bssc_pkg::ITER_W-1:0] iter;
  logic [31:0]               res_step;
  logic                      res_status, res_conv;
  bssc_pkg::md_req_t         req;
  bssc_pkg::md_rsp_t         rsp;

  // Combinational helpers for the Newton update and the final clamp.
  logic [63:0] md_q, den, mag, dx, r_new, hi_c, cl;
  logic [51:0] dx_tol;
  logic        pos, conv_c;

  assign md_q = rsp.q;
  assign den  = 64'((r << 1) + bssc_pkg::ONE_Q32 + md_q);
  assign pos  = a >= t;
  assign mag  = pos ? a - t : t - a;
  assign dx   = md_q;

  always_comb begin
    if (pos) r_new = (dx >= r) ? 64'd1 : r - dx;
    else     r_new = (dx >= bssc_pkg::R_CAP - r) ? bssc_pkg::R_CAP : r + dx;
    if (r_new == 64'd0) r_new = 64'd1;
    dx_tol = 52'(dx[41:0] * bssc_pkg::TOL_INV);
    conv_c = (dx <= r_new) && (dx_tol < 52'(r_new[41:0]));
    hi_c   = md_q;
    cl     = (hi_c < nxt) ? hi_c : nxt;
    if (lo > cl) cl = lo;
    if (frozen && cl > {32'd0, h}) cl = {32'd0, h};
  end

  bssc_muldiv u_md (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp)
  );

  assign in_stall = (state != S_IDLE);

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      ratio_min    <= 32'd4194304;
      ratio_max    <= 32'd67108864;
      reject_limit <= 32'd67108864;
      error_floor  <= 32'd16777;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bssc_pkg::REG_RATIO_MIN:    ratio_min    <= cfg_data;
        bssc_pkg::REG_RATIO_MAX:    ratio_max    <= cfg_data;
        bssc_pkg::REG_REJECT_LIMIT: reject_limit <= cfg_data;
        bssc_pkg::REG_ERROR_FLOOR:  error_floor  <= cfg_data;
      endcase
    end
  end

  // Sequencer: each arithmetic state waits for the unit, then stores, launches or both.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      req.start <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      req.start <= 1'b0;
      if (out_valid && !out_stall && state != S_DONE) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            h          <= step_now;
            d2         <= hist_delta_two;
            frozen     <= freeze_active;
            res_status <= 1'b0;
            res_conv   <= 1'b0;
            r          <= bssc_pkg::ONE_Q32;
            iter       <= '0;
            if (!error_control_on) begin
              res_step <= step_now;
              state    <= S_DONE;
            end else if (pred_error >= reject_limit) begin
              res_step   <= step_now >> 1;
              res_status <= 1'b1;
              state      <= S_DONE;
            end else if (step_now == 32'd0) begin
              res_step <= 32'd0;
              state    <= S_DONE;
            end else begin
              e <= (pred_error > error_floor) ? {32'd0, pred_error} :
                   (error_floor != 32'd0) ? {32'd0, error_floor} : 64'd1;
              req.start <= 1'b1;
              req.a     <= 64'(step_now) + 64'(hist_delta_one);
              req.b     <= bssc_pkg::ONE_Q32;
              req.d     <= {32'd0, step_now};
              state     <= S_P;
            end
          end
        end
        S_P: if (rsp.done) begin
          p         <= (md_q < bssc_pkg::PQ_CAP) ? md_q : bssc_pkg::PQ_CAP;
          req.start <= 1'b1;
          req.a     <= 64'(h) + 64'(d2);
          req.b     <= bssc_pkg::ONE_Q32;
          req.d     <= {32'd0, h};
          state     <= S_Q;
        end
        S_Q: if (rsp.done) begin
          q         <= (md_q < bssc_pkg::PQ_CAP) ? md_q : bssc_pkg::PQ_CAP;
          rp        <= r + p;
          req.start <= 1'b1;
          req.a     <= r;
          req.b     <= r + bssc_pkg::ONE_Q32;
          req.d     <= bssc_pkg::ONE_Q32;
          state     <= S_A;
        end
        S_A: if (rsp.done) begin
          a         <= md_q;
          req.start <= 1'b1;
          req.a     <= p;
          req.b     <= q;
          req.d     <= rp;
          state     <= S_T1;
        end
        S_T1: if (rsp.done) begin
          req.start <= 1'b1;
          req.a     <= md_q;
          req.b     <= 64'd1 << (bssc_pkg::FRAC_BITS - 1);
          req.d     <= e;
          state     <= S_T2;
        end
        S_T2: if (rsp.done) begin
          t         <= (md_q < bssc_pkg::T_CAP) ? md_q : bssc_pkg::T_CAP;
          req.start <= 1'b1;
          req.a     <= a;
          req.b     <= bssc_pkg::ONE_Q32;
          req.d     <= rp;
          state     <= S_DEN;
        end
        S_DEN: if (rsp.done) begin
          req.start <= 1'b1;
          req.a     <= mag;
          req.b     <= bssc_pkg::ONE_Q32;
          req.d     <= den;
          state     <= S_DX;
        end
        S_DX: if (rsp.done) begin
          r         <= r_new;
          iter      <= iter + 1'b1;
          req.start <= 1'b1;
          if (conv_c || iter == bssc_pkg::ITER_W'(bssc_pkg::MAX_ITER - 1)) begin
            res_conv <= conv_c;
            req.a    <= r_new;
            req.b    <= {32'd0, h};
            req.d    <= bssc_pkg::ONE_Q32;
            state    <= S_N;
          end else begin
            rp    <= r_new + p;
            req.a <= r_new;
            req.b <= r_new + bssc_pkg::ONE_Q32;
            req.d <= bssc_pkg::ONE_Q32;
            state <= S_A;
          end
        end
        S_N: if (rsp.done) begin
          nxt       <= md_q;
          req.start <= 1'b1;
          req.a     <= {32'd0, ratio_min};
          req.b     <= {32'd0, h};
          req.d     <= 64'd1 << bssc_pkg::FRAC_BITS;
          state     <= S_LO;
        end
        S_LO: if (rsp.done) begin
          lo        <= md_q;
          req.start <= 1'b1;
          req.a     <= {32'd0, ratio_max};
          req.b     <= {32'd0, h};
          req.d     <= 64'd1 << bssc_pkg::FRAC_BITS;
          state     <= S_HI;
        end
        S_HI: if (rsp.done) begin
          res_step <= (cl > 64'h0000_0000_FFFF_FFFF) ? 32'hFFFF_FFFF : cl[31:0];
          state    <= S_DONE;
        end
        default: begin
          // Load the output register once it is free.
          if (!out_valid || !out_stall) begin
            next_step        <= res_step;
            step_status      <= res_status;
            newton_converged <= res_conv;
            out_valid        <= 1'b1;
            state            <= S_IDLE;
          end
        end
      endcase
    end
  end

endmodule

### src/bssc_muldiv.sv
// Shared multiply-divide unit: 64x64 product from four 32x32 partial products, then a
// restoring divide one quotient bit per cycle; divisors 2^32 and 2^FRAC_BITS are shifts.
// Depends on bssc_pkg.
module bssc_muldiv (
  input  logic             clk,
  input  logic             rst,
  input  bssc_pkg::md_req_t req,
  output bssc_pkg::md_rsp_t rsp
);

  typedef enum logic [1:0] {M_IDLE, M_MUL, M_CHK, M_DIV} mstate_t;

  mstate_t      state;
  logic [2:0]   step;
  logic [6:0]   cnt;
  logic [63:0]  op_a, op_b, op_d;
  logic [63:0]  pp;
  logic [6:0]   pp_sh;
  logic [127:0] prod;
  logic [63:0]  rem, lo, quo;
  logic [31:0]  ma, mb;
  logic [6:0]   msh;
  logic [64:0]  rem_sh;
  logic         take;

  // Operand halves for the current partial product.
  always_comb begin
    unique case (step[1:0])
      2'd0: begin ma = op_a[31:0];  mb = op_b[31:0];  msh = 7'd0;  end
      2'd1: begin ma = op_a[31:0];  mb = op_b[63:32]; msh = 7'd32; end
      2'd2: begin ma = op_a[63:32]; mb = op_b[31:0];  msh = 7'd32; end
      default: begin ma = op_a[63:32]; mb = op_b[63:32]; msh = 7'd64; end
    endcase
  end

  // One divide step on the shifted partial remainder.
  assign rem_sh = {rem, lo[63]};
  assign take   = rem_sh >= {1'b0, op_d};

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= M_IDLE;
      rsp.done <= 1'b0;
    end else begin
      rsp.done <= 1'b0;
      unique case (state)
        M_IDLE: begin
          if (req.start) begin
            op_a  <= req.a;
            op_b  <= req.b;
            op_d  <= req.d;
            prod  <= '0;
            step  <= '0;
            state <= M_MUL;
          end
        end
        M_MUL: begin
          // Multiply into the pp register, accumulate the registered product the next.
          if (step < 3'd4) begin
            pp    <= ma * mb;
            pp_sh <= msh;
          end
          if (step != 3'd0) prod <= prod + ({64'd0, pp} << pp_sh);
          step <= step + 3'd1;
          if (step == 3'd4) state <= M_CHK;
        end
        M_CHK: begin
          if (op_d == 64'd0 || prod[127:64] >= op_d) begin
            rsp.q    <= '1;
            rsp.done <= 1'b1;
            state    <= M_IDLE;
          end else if (op_d == bssc_pkg::ONE_Q32) begin
            // Divisors 2^32 and 2^FRAC_BITS need only a shift of the product.
            rsp.q    <= prod[95:32];
            rsp.done <= 1'b1;
            state    <= M_IDLE;
          end else if (op_d == (64'd1 << bssc_pkg::FRAC_BITS)) begin
            rsp.q    <= prod[bssc_pkg::FRAC_BITS +: 64];
            rsp.done <= 1'b1;
            state    <= M_IDLE;
          end else begin
            rem   <= prod[127:64];
            lo    <= prod[63:0];
            quo   <= '0;
            cnt   <= '0;
            state <= M_DIV;
          end
        end
        default: begin
          rem <= take ? 64'(rem_sh - {1'b0, op_d}) : rem_sh[63:0];
          lo  <= lo << 1;
          quo <= {quo[62:0], take};
          cnt <= cnt + 7'd1;
          if (cnt == 7'd63) begin
            rsp.q    <= {quo[62:0], take};
            rsp.done <= 1'b1;
            state    <= M_IDLE;
          end
        end
      endcase
    end
  end

endmodule

### src/bssc_checker.sv
// Port-level checks for the BDF2 step-size controller.
// Bound to the top level; depends only on its ports.
module bssc_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] next_step,
  input logic        step_status,
  input logic        newton_converged
);

  // A held result stays valid and keeps its next_step value.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(next_step))
    else $error("result changed while stalled");

  // An accepted request makes the block busy.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("block not busy after a request");

  // A rejected step never reports convergence.
  a_rej: assert property (@(posedge clk) disable iff (rst)
    out_valid && step_status |-> !newton_converged)
    else $error("rejected step marked converged");

  // Reset leaves no result pending.
  a_rst: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result pending after reset");

endmodule

bind bdf2_step_size_controller bssc_checker u_chk (
  .clk(clk),
  .rst(rst),
  .in_valid(in_valid),
  .in_stall(in_stall),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .next_step(next_step),
  .step_status(step_status),
  .newton_converged(newton_converged)
);

### test/bdf2_step_size_controller_test.sv
// Self-checking testbench for the BDF2 step-size controller.
// Depends on bssc_pkg and bdf2_step_size_controller; predicts each step request internally.
`timescale 1ns / 100ps

module bdf2_step_size_controller_test;

  localparam longint CYCLE_LIMIT = 64'd40_000_000;

  typedef struct {
    logic [31:0] h;
    logic [31:0] d1;
    logic [31:0] d2;
    logic [31:0] err;
    logic        frz;
    logic        ectrl;
  } step_req_t;

  typedef struct {
    logic [31:0] next;
    logic        status;
    logic        conv;
  } step_res_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [31:0] step_now = '0, hist_delta_one = '0, hist_delta_two = '0, pred_error = '0;
  logic        freeze_active = 1'b0, error_control_on = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] next_step;
  logic        step_status, newton_converged;

  // Predictor copy of the registers.
  logic [63:0] ratio_min_q, ratio_max_q, reject_limit_q, error_floor_q;

  step_req_t pending_steps[$];
  step_res_t expected_steps[$];
  int  errors = 0;
  int  checked = 0;
  int  converged_seen = 0;
  int  rejected_seen = 0;
  longint cycles = 0;
  int  gap_left = 0;
  int  burst_left = 0;
  int  stall_mode = 0;
  int  stall_count = 0;

  bdf2_step_size_controller i_dut (.*);

  always #10 clk = ~clk;

  // floor(a*b/d) with saturation to all ones.
  function automatic logic [63:0] mul_div(logic [63:0] a, logic [63:0] b, logic [63:0] d);
    logic [127:0] prod, quot;
    prod = {64'b0, a} * {64'b0, b};
    if (d == 0) return '1;
    quot = prod / {64'b0, d};
    if (quot[127:64] != 0) return '1;
    return quot[63:0];
  endfunction

  function automatic step_res_t predict_step(step_req_t s);
    step_res_t res;
    logic [63:0] h, e, p, q, r, rp, a, t, den, mag, dx, lo, hi, nxt;
    logic pos;
    h = {32'b0, s.h};
    res.status = 1'b0;
    res.conv = 1'b0;
    if (!s.ectrl) begin
      nxt = h;
    end else if ({32'b0, s.err} >= reject_limit_q) begin
      nxt = h >> 1;
      res.status = 1'b1;
    end else if (h == 0) begin
      nxt = 0;
    end else begin
      e = ({32'b0, s.err} > error_floor_q) ? {32'b0, s.err} : error_floor_q;
      if (e == 0) e = 1;
      p = mul_div(h + s.d1, bssc_pkg::ONE_Q32, h);
      if (p > bssc_pkg::PQ_CAP) p = bssc_pkg::PQ_CAP;
      q = mul_div(h + s.d2, bssc_pkg::ONE_Q32, h);
      if (q > bssc_pkg::PQ_CAP) q = bssc_pkg::PQ_CAP;
      r = bssc_pkg::ONE_Q32;
      // Newton iteration on the cubic in the step ratio.
      for (int it = 0; it < bssc_pkg::MAX_ITER; it++) begin
        rp = r + p;
        a = mul_div(r, r + bssc_pkg::ONE_Q32, bssc_pkg::ONE_Q32);
        t = mul_div(mul_div(p, q, rp), 64'd1 << (bssc_pkg::FRAC_BITS - 1), e);
        if (t > bssc_pkg::T_CAP) t = bssc_pkg::T_CAP;
        pos = a >= t;
        mag = pos ? a - t : t - a;
        den = 2 * r + bssc_pkg::ONE_Q32 + mul_div(a, bssc_pkg::ONE_Q32, rp);
        dx = mul_div(mag, bssc_pkg::ONE_Q32, den);
        if (pos) r = (dx >= r) ? 64'd1 : r - dx;
        else r = (dx >= bssc_pkg::R_CAP - r) ? bssc_pkg::R_CAP : r + dx;
        if (r < 1) r = 1;
        if (dx <= r && dx * bssc_pkg::TOL_INV < r) begin
          res.conv = 1'b1;
          break;
        end
      end
      nxt = mul_div(r, h, bssc_pkg::ONE_Q32);
      lo = mul_div(ratio_min_q, h, 64'd1 << bssc_pkg::FRAC_BITS);
      hi = mul_div(ratio_max_q, h, 64'd1 << bssc_pkg::FRAC_BITS);
      if (hi < nxt) nxt = hi;
      if (lo > nxt) nxt = lo;
      if (s.frz && h < nxt) nxt = h;
      if (nxt > 64'hFFFF_FFFF) nxt = 64'hFFFF_FFFF;
    end
    res.next = nxt[31:0];
    return res;
  endfunction

  // Driver: bursts of requests with random gaps.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!(in_valid && in_stall)) begin
      if (in_valid) begin
        expected_steps.push_back(predict_step(pending_steps.pop_front()));
      end
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (pending_steps.size() > 0) begin
        in_valid <= 1'b1;
        step_now <= pending_steps[0].h;
        hist_delta_one <= pending_steps[0].d1;
        hist_delta_two <= pending_steps[0].d2;
        pred_error <= pending_steps[0].err;
        freeze_active <= pending_steps[0].frz;
        error_control_on <= pending_steps[0].ectrl;
        if (burst_left <= 0) begin
          burst_left <= $urandom_range(1, 8);
          gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: receiver stall pattern and result check.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_steps.size() == 0) begin
          $display("%0t: unexpected result next_step=%h", $time, next_step);
          errors++;
        end else begin
          step_res_t exp_res;
          exp_res = expected_steps.pop_front();
          checked++;
          if (exp_res.conv) converged_seen++;
          if (exp_res.status) rejected_seen++;
          if (next_step !== exp_res.next) begin
            $display("%0t: next_step expected %h actual %h", $time, exp_res.next, next_step);
            errors++;
          end
          if (step_status !== exp_res.status) begin
            $display("%0t: step_status expected %b actual %b", $time, exp_res.status,
                     step_status);
            errors++;
          end
          if (newton_converged !== exp_res.conv) begin
            $display("%0t: newton_converged expected %b actual %b", $time, exp_res.conv,
                     newton_converged);
            errors++;
          end
        end
      end
      stall_count <= stall_count + 1;
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 2) == 0);
        default: out_stall <= (stall_count % 23) < 9;
      endcase
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      bssc_pkg::REG_RATIO_MIN:    ratio_min_q = {32'b0, val};
      bssc_pkg::REG_RATIO_MAX:    ratio_max_q = {32'b0, val};
      bssc_pkg::REG_REJECT_LIMIT: reject_limit_q = {32'b0, val};
      default:                    error_floor_q = {32'b0, val};
    endcase
  endtask

  task automatic add_step(logic [31:0] h, logic [31:0] d1, logic [31:0] d2,
                          logic [31:0] err, logic frz, logic ectrl);
    step_req_t s;
    s = '{h, d1, d2, err, frz, ectrl};
    pending_steps.push_back(s);
  endtask

  // Random value spread over magnitudes, with occasional full-width values.
  function automatic logic [31:0] spread_val();
    logic [31:0] v;
    v = $urandom;
    if ($urandom_range(0, 3) != 0) v = v >> $urandom_range(0, 31);
    return v;
  endfunction

  task automatic add_random_steps(int n);
    logic [31:0] err;
    for (int i = 0; i < n; i++) begin
      // Mostly accepted errors so the Newton solve runs.
      case ($urandom_range(0, 9))
        0: err = $urandom;
        1: err = reject_limit_q[31:0] + $urandom_range(0, 3);
        default: err = (reject_limit_q == 0) ? 32'd0 :
                       32'($urandom % reject_limit_q[31:0]);
      endcase
      add_step(($urandom_range(0, 9) == 0) ? $urandom : spread_val(), spread_val(),
               spread_val(), err, $urandom_range(0, 1), $urandom_range(0, 7) != 0);
    end
  endtask

  task automatic drain();
    wait (pending_steps.size() == 0 && expected_steps.size() == 0 && !in_valid);
    repeat (10) @(posedge clk);
  endtask

  initial begin
    ratio_min_q = 64'd4194304;
    ratio_max_q = 64'd67108864;
    reject_limit_q = 64'd67108864;
    error_floor_q = 64'd16777;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed requests at the reset settings.
    add_step(32'h0100_0000, 32'h0100_0000, 32'h0100_0000, 32'h0000_4000, 1'b0, 1'b0);
    add_step(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b0);
    add_step(32'h0100_0000, 32'h0, 32'h0, 32'h0400_0000, 1'b0, 1'b1);
    add_step(32'hFFFF_FFFF, 32'h0, 32'h0, 32'hFFFF_FFFF, 1'b0, 1'b1);
    add_step(32'h0, 32'h0100_0000, 32'h0100_0000, 32'h0000_1000, 1'b0, 1'b1);
    add_step(32'h0100_0000, 32'h0100_0000, 32'h0100_0000, 32'h0010_0000, 1'b0, 1'b1);
    add_step(32'h0100_0000, 32'h0100_0000, 32'h0100_0000, 32'h0010_0000, 1'b1, 1'b1);
    add_step(32'h0100_0000, 32'h0100_0000, 32'h0100_0000, 32'h0, 1'b0, 1'b1);
    add_step(32'h0000_0001, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 1'b0, 1'b1);
    add_step(32'h0000_0001, 32'h0, 32'h0, 32'h03FF_FFFF, 1'b0, 1'b1);
    add_step(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0001, 1'b0, 1'b1);
    add_step(32'h8000_0000, 32'h0, 32'h0, 32'h03FF_FFFF, 1'b1, 1'b1);
    add_step(32'h0001_0000, 32'h0010_0000, 32'h0000_0100, 32'h0100_0000, 1'b0, 1'b1);
    drain();

    // Extreme settings: wide clamp, highest reject limit, zero floor.
    write_reg(bssc_pkg::REG_RATIO_MIN, 32'h0);
    write_reg(bssc_pkg::REG_RATIO_MAX, 32'hFFFF_FFFF);
    write_reg(bssc_pkg::REG_REJECT_LIMIT, 32'hFFFF_FFFF);
    write_reg(bssc_pkg::REG_ERROR_FLOOR, 32'h0);
    add_step(32'h0100_0000, 32'h0100_0000, 32'h0100_0000, 32'h0, 1'b0, 1'b1);
    add_step(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 1'b0, 1'b1);
    add_step(32'h0000_0001, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFE, 1'b0, 1'b1);
    stall_mode = 1;
    add_random_steps(250);
    drain();

    // Crossed clamp bounds, every error rejected when error control is on.
    write_reg(bssc_pkg::REG_RATIO_MIN, 32'hFFFF_FFFF);
    write_reg(bssc_pkg::REG_RATIO_MAX, 32'h0);
    write_reg(bssc_pkg::REG_REJECT_LIMIT, 32'h0);
    write_reg(bssc_pkg::REG_ERROR_FLOOR, 32'hFFFF_FFFF);
    stall_mode = 2;
    add_random_steps(100);
    drain();

    // Crossed bounds with solves running and a huge floor.
    write_reg(bssc_pkg::REG_REJECT_LIMIT, 32'hFFFF_FFFF);
    add_random_steps(150);
    drain();

    // Random settings.
    for (int ph = 0; ph < 5; ph++) begin
      write_reg(bssc_pkg::REG_RATIO_MIN, $urandom_range(0, 32'h0100_0000));
      write_reg(bssc_pkg::REG_RATIO_MAX, $urandom_range(32'h0080_0000, 32'h1000_0000));
      write_reg(bssc_pkg::REG_REJECT_LIMIT, spread_val());
      write_reg(bssc_pkg::REG_ERROR_FLOOR, spread_val());
      stall_mode = ph % 3;
      add_random_steps(200);
      drain();
    end

    // Back to the reset values for a final stretch.
    write_reg(bssc_pkg::REG_RATIO_MIN, 32'd4194304);
    write_reg(bssc_pkg::REG_RATIO_MAX, 32'd67108864);
    write_reg(bssc_pkg::REG_REJECT_LIMIT, 32'd67108864);
    write_reg(bssc_pkg::REG_ERROR_FLOOR, 32'd16777);
    stall_mode = 1;
    add_random_steps(100);
    drain();

    $display("Checked %0d step requests under ten register settings", checked);
    $display("(%0d rejected, %0d converged).", rejected_seen, converged_seen);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
